// ----- rtl/laguerre_polynomial_sequence_core_assert.svh -----
// assertion macros for the laguerre sequence core
// bodies expect clk_i and rst_ni in the scope of the use
`ifndef LAGUERRE_POLYNOMIAL_SEQUENCE_CORE_ASSERT_SVH
`define LAGUERRE_POLYNOMIAL_SEQUENCE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lps assertion failed");

`define LPS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lps assertion failed");

`else

`define LPS_ASSERT(lbl, prop)

`define LPS_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ----- rtl/lps_pkg.sv -----
// shared widths, constants, types and states of the laguerre sequence core
// no dependencies
package lps_pkg;

  localparam int unsigned XW        = 32;
  localparam int unsigned ORD_W     = 6;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned ACC_W     = 2 * VAL_W;
  localparam int unsigned DIV_W     = ACC_W - 32;
  localparam int unsigned DIV_STEP  = 4;
  localparam int unsigned DIV_ITER  = DIV_W / DIV_STEP;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITER);

  localparam logic [ORD_W-1:0] MAX_ORDER = ORD_W'(63);
  localparam logic [VAL_W-1:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [VAL_W-1:0] SIGN64    = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [ORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OUT,
    ST_ALPHA,
    ST_SETUP,
    ST_MUL,
    ST_MAG,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

// ----- rtl/lps_ifs.sv -----
// valid/ready channel interfaces for argument items and result items
// depends on lps_pkg
interface lps_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [lps_pkg::XW-1:0]  x_arg;
  logic [lps_pkg::ORD_W-1:0]      top_order;

  modport source (output valid, x_arg, top_order, input ready);
  modport sink   (input valid, x_arg, top_order, output ready);
endinterface

interface lps_out_if;
  logic                             valid;
  logic                             ready;
  logic [lps_pkg::ORD_W-1:0]        order_index;
  logic signed [lps_pkg::VAL_W-1:0] poly_value;
  logic                             overflow;
  logic                             last;

  modport source (output valid, order_index, poly_value, overflow, last, input ready);
  modport sink   (input valid, order_index, poly_value, overflow, last, output ready);
endinterface

// ----- rtl/lps_div_unit.sv -----
// iterative divider of a wide unsigned dividend by a small unsigned divisor
// four quotient bits per cycle, depends on lps_pkg
module lps_div_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lps_pkg::div_req_t req_i,
  output lps_pkg::div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [lps_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [lps_pkg::ORD_W-1:0]       rem_q, rem_d;
  logic [lps_pkg::ORD_W-1:0]       dvs_q;
  logic [lps_pkg::DIV_W-1:0]       dq_q, dq_d;

  always_comb begin
    logic [lps_pkg::ORD_W:0]          t;
    logic [lps_pkg::ORD_W-1:0]        r;
    logic [lps_pkg::DIV_STEP-1:0]     qb;
    r  = rem_q;
    qb = '0;
    for (int b = 0; b < lps_pkg::DIV_STEP; b++) begin
      t = {r, dq_q[lps_pkg::DIV_W-1-b]};
      if (t >= {1'b0, dvs_q}) begin
        qb[lps_pkg::DIV_STEP-1-b] = 1'b1;
        r = lps_pkg::ORD_W'(t - {1'b0, dvs_q});
      end else begin
        r = t[lps_pkg::ORD_W-1:0];
      end
    end
    rem_d  = r;
    dq_d   = {dq_q[lps_pkg::DIV_W-lps_pkg::DIV_STEP-1:0], qb};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q + lps_pkg::DIV_CNT_W'(1);
      if (cnt_q == lps_pkg::DIV_CNT_W'(lps_pkg::DIV_ITER - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

// ----- rtl/laguerre_polynomial_sequence_core.sv -----
// laguerre polynomial sequence core: L0(x)..Ln(x) in signed Q32.32, saturated
// L0 is valid in the cycle after the input transfer, L1 in the cycle after the L0 transfer;
// each later order is computed after the previous transfer in the alpha and setup states,
// the 32x32 partial product multiply, magnitude, divider at four bits a cycle, and finish
// a new argument is accepted only after the last order of the sequence has been transferred
// reset: asynchronous active low, returns to idle with the sequence state cleared
module laguerre_polynomial_sequence_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lps_in_if.sink    in_i,
  lps_out_if.source out_o
);

`include "laguerre_polynomial_sequence_core_assert.svh"

  lps_pkg::state_e              state_q, state_d;

  logic [lps_pkg::VAL_W-1:0]    prev_q, curr_q, one_mx_q;
  logic [lps_pkg::ORD_W-1:0]    step_q, top_q;
  logic                         sat_q;

  logic [lps_pkg::VAL_W-1:0]    alpha_q;
  logic [lps_pkg::VAL_W-1:0]    mag_a0_q, mag_b0_q, mag_a1_q, mag_b1_q;
  logic                         neg0_q, neg1_q;

  logic [3:0]                   mcnt_q;
  logic [lps_pkg::VAL_W-1:0]    prod_q;
  logic                         prod_vld_q, prod_neg_q;
  logic [1:0]                   prod_sh_q;
  logic [lps_pkg::ACC_W-1:0]    acc_q;
  logic                         neg_q;

  lps_pkg::div_req_t            div_req;
  lps_pkg::div_rsp_t            div_rsp;

  logic                         in_xfer, out_xfer, out_last;
  logic [lps_pkg::ORD_W-1:0]    top_clamp;
  logic [lps_pkg::VAL_W-1:0]    xq;
  logic [31:0]                  a_h, b_h;
  logic [lps_pkg::VAL_W-1:0]    opa, opb, prod_d;
  logic [lps_pkg::ACC_W-1:0]    ext, acc_mag;
  logic [lps_pkg::VAL_W-1:0]    limit, qlo, v_next;
  logic                         sat_now;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign out_xfer  = out_o.valid && out_o.ready;
  assign out_last  = (step_q == top_q);
  assign top_clamp = (in_i.top_order > lps_pkg::MAX_ORDER) ? lps_pkg::MAX_ORDER
                                                           : in_i.top_order;
  assign xq        = {{16{in_i.x_arg[lps_pkg::XW-1]}}, in_i.x_arg, 16'b0};

  // partial product select
  assign opa    = mcnt_q[2] ? mag_a1_q : mag_a0_q;
  assign opb    = mcnt_q[2] ? mag_b1_q : mag_b0_q;
  assign a_h    = mcnt_q[1] ? opa[63:32] : opa[31:0];
  assign b_h    = mcnt_q[0] ? opb[63:32] : opb[31:0];
  assign prod_d = {32'b0, a_h} * {32'b0, b_h};

  always_comb begin
    case (prod_sh_q)
      2'd0:    ext = {64'b0, prod_q};
      2'd1:    ext = {32'b0, prod_q, 32'b0};
      2'd2:    ext = {prod_q, 64'b0};
      default: ext = '0;
    endcase
  end

  assign acc_mag = acc_q[lps_pkg::ACC_W-1] ? (~acc_q + lps_pkg::ACC_W'(1)) : acc_q;

  assign qlo     = div_rsp.quotient[lps_pkg::VAL_W-1:0];
  assign limit   = neg_q ? lps_pkg::SIGN64 : (lps_pkg::SIGN64 - lps_pkg::VAL_W'(1));
  assign sat_now = (div_rsp.quotient[lps_pkg::DIV_W-1:lps_pkg::VAL_W] != '0) || (qlo > limit);
  assign v_next  = sat_now ? limit : (neg_q ? (~qlo + lps_pkg::VAL_W'(1)) : qlo);

  assign div_req.start    = (state_q == lps_pkg::ST_MAG);
  assign div_req.dividend = acc_mag[lps_pkg::ACC_W-1:32];
  assign div_req.divisor  = step_q + lps_pkg::ORD_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lps_pkg::ST_IDLE:  if (in_xfer) state_d = lps_pkg::ST_OUT;
      lps_pkg::ST_OUT: begin
        if (out_xfer) begin
          if (out_last)                state_d = lps_pkg::ST_IDLE;
          else if (step_q == '0)       state_d = lps_pkg::ST_OUT;
          else                         state_d = lps_pkg::ST_ALPHA;
        end
      end
      lps_pkg::ST_ALPHA: state_d = lps_pkg::ST_SETUP;
      lps_pkg::ST_SETUP: state_d = lps_pkg::ST_MUL;
      lps_pkg::ST_MUL:   if (mcnt_q[3]) state_d = lps_pkg::ST_MAG;
      lps_pkg::ST_MAG:   state_d = lps_pkg::ST_DIV;
      lps_pkg::ST_DIV:   if (div_rsp.done) state_d = lps_pkg::ST_FIN;
      lps_pkg::ST_FIN:   state_d = lps_pkg::ST_OUT;
      default:           state_d = lps_pkg::ST_IDLE;
    endcase
  end

  // handshake control
  always_comb begin
    in_i.ready    = 1'b0;
    out_o.valid   = 1'b0;
    case (state_q)
      lps_pkg::ST_IDLE: in_i.ready    = 1'b1;
      lps_pkg::ST_OUT:  out_o.valid   = 1'b1;
      default: begin
        in_i.ready    = 1'b0;
        out_o.valid   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lps_pkg::ST_IDLE;
      step_q     <= '0;
      top_q      <= '0;
      sat_q      <= 1'b0;
      prev_q     <= '0;
      curr_q     <= '0;
      mcnt_q     <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      prod_vld_q <= (state_q == lps_pkg::ST_MUL) && !mcnt_q[3];
      case (state_q)
        lps_pkg::ST_IDLE: begin
          if (in_xfer) begin
            top_q  <= top_clamp;
            step_q <= '0;
            sat_q  <= 1'b0;
            prev_q <= '0;
            curr_q <= lps_pkg::ONE_Q32;
          end
        end
        lps_pkg::ST_OUT: begin
          if (out_xfer && !out_last && step_q == '0) begin
            prev_q <= curr_q;
            curr_q <= one_mx_q;
            step_q <= lps_pkg::ORD_W'(1);
          end
        end
        lps_pkg::ST_SETUP: mcnt_q <= '0;
        lps_pkg::ST_MUL:   mcnt_q <= mcnt_q + 4'd1;
        lps_pkg::ST_FIN: begin
          prev_q <= curr_q;
          curr_q <= v_next;
          step_q <= step_q + lps_pkg::ORD_W'(1);
          if (sat_now) sat_q <= 1'b1;
        end
        default: mcnt_q <= mcnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) one_mx_q <= lps_pkg::ONE_Q32 - xq;
    if (state_q == lps_pkg::ST_ALPHA) begin
      alpha_q <= {25'b0, step_q, 1'b0, 32'b0} + one_mx_q;
    end
    if (state_q == lps_pkg::ST_SETUP) begin
      mag_a0_q <= alpha_q[63] ? (~alpha_q + 64'd1) : alpha_q;
      mag_b0_q <= curr_q[63] ? (~curr_q + 64'd1) : curr_q;
      mag_a1_q <= {26'b0, step_q, 32'b0};
      mag_b1_q <= prev_q[63] ? (~prev_q + 64'd1) : prev_q;
      neg0_q   <= alpha_q[63] ^ curr_q[63];
      neg1_q   <= !prev_q[63];
      acc_q    <= '0;
    end else if (prod_vld_q) begin
      acc_q <= prod_neg_q ? (acc_q - ext) : (acc_q + ext);
    end
    if (state_q == lps_pkg::ST_MUL) begin
      prod_q     <= prod_d;
      prod_neg_q <= mcnt_q[2] ? neg1_q : neg0_q;
      prod_sh_q  <= {1'b0, mcnt_q[1]} + {1'b0, mcnt_q[0]};
    end
    if (state_q == lps_pkg::ST_MAG) neg_q <= acc_q[lps_pkg::ACC_W-1];
  end

  lps_div_unit u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_o.order_index = step_q;
  assign out_o.poly_value  = curr_q;
  assign out_o.overflow    = sat_q;
  assign out_o.last        = out_last;

  `LPS_ASSERT(a_no_accept_while_holding, !(in_i.ready && out_o.valid))
  `LPS_ASSERT_NEXT(a_first_is_order_zero, in_xfer,
                   out_o.valid && out_o.order_index == '0 && !out_o.overflow)
  `LPS_ASSERT_NEXT(a_last_frees_input, out_xfer && out_o.last, in_i.ready)
  `LPS_ASSERT(a_div_done_in_div, !div_rsp.done || state_q == lps_pkg::ST_DIV)

endmodule
